// ===== hw/rtl/lrs_pkg.sv =====
package lrs_pkg;

    // Defaults of the top-level parameters.
    localparam int MAX_SIDE_DEF   = 64;
    localparam int VALUE_BITS_DEF = 18;

    // Fixed field widths.
    localparam int MODE_W    = 2;
    localparam int INDEX_W   = 6;
    localparam int SWEEP_W   = 16;
    localparam int SIDE_CFG_W = 7;
    localparam int TOL_W     = 16;
    localparam int OMEGA_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELAX       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_LIMIT = 2'd3;

    // Register reset values.
    localparam logic [SIDE_CFG_W-1:0] GRID_SIDE_RST   = 7'd64;
    localparam logic [TOL_W-1:0]      TOLERANCE_RST   = 16'd7;
    localparam logic [OMEGA_W-1:0]    RELAX_RST       = 17'd65536;
    localparam logic [SWEEP_W-1:0]    SWEEP_LIMIT_RST = 16'd65535;

    // Operation codes carried by the mode field.
    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_SOLVE = 2'd1,
        MODE_READ  = 2'd2
    } mode_t;

endpackage

// ===== hw/rtl/lrs_ifs.sv =====
interface lrs_req_if #(
    parameter int VALUE_BITS = lrs_pkg::VALUE_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic [lrs_pkg::MODE_W-1:0]         mode;
    logic [lrs_pkg::INDEX_W-1:0]        row;
    logic [lrs_pkg::INDEX_W-1:0]        column;
    logic signed [VALUE_BITS-1:0]       cell_in;
    logic                               held;

    modport source (output valid, mode, row, column, cell_in, held, input ready);
    modport sink (input valid, mode, row, column, cell_in, held, output ready);
endinterface

interface lrs_rsp_if #(
    parameter int VALUE_BITS = lrs_pkg::VALUE_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic signed [VALUE_BITS-1:0]       cell_out;
    logic [lrs_pkg::SWEEP_W-1:0]        sweeps;
    logic                               converged;

    modport source (output valid, cell_out, sweeps, converged, input ready);
    modport sink (input valid, cell_out, sweeps, converged, output ready);
endinterface

// ===== hw/rtl/laplace_relaxation_solver.sv =====
// Laplace relaxation solver, 5-point Gauss-Seidel with over-relaxation.
// Words arrive on req (valid/ready) and every accepted word yields exactly
// one word on rsp. A write word stores a potential and its held flag; a read
// word returns one cell; a solve word sweeps the interior of the grid in
// row-major order until the largest change of a sweep falls below the
// tolerance or the sweep limit is reached.
// Write and read words are taken one per cycle while the response register
// is free; the response is valid in the cycle after acceptance (a read
// returns data from the grid memory then). A solve holds the block: each
// free interior cell update fetches its center and four neighbors through
// the single read port of the grid memory, then multiplies and writes back;
// the response follows the last sweep. req.ready is high only while no solve
// runs and the response register is empty or being taken, so a stalled
// receiver holds the pending word and stops new words. Reset clears the
// control state and loads the register defaults; the grid memory is not
// cleared and cells must be written before they are read or swept. The user
// must write configuration only while idle; the block does not check.
module laplace_relaxation_solver #(
    parameter int MAX_SIDE   = lrs_pkg::MAX_SIDE_DEF,
    parameter int VALUE_BITS = lrs_pkg::VALUE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    lrs_req_if.sink                          req,
    lrs_rsp_if.source                        rsp,
    input  logic                             cfg_we,
    input  logic [lrs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lrs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lrs_pkg::*;

    localparam int CELLS     = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_BITS = $clog2(CELLS);
    localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
    localparam int CMP_W     = (SIDE_W > SIDE_CFG_W) ? SIDE_W : SIDE_CFG_W;
    localparam int SUM_W     = VALUE_BITS + 2;
    localparam int DIFF_W    = VALUE_BITS + 1;
    localparam int PROD_W    = OMEGA_W + 1 + DIFF_W;
    localparam int CHG_CMP_W = (VALUE_BITS > TOL_W) ? VALUE_BITS : TOL_W;

    localparam logic signed [PROD_W-1:0] VMAX_P = PROD_W'((64'sd1 <<< (VALUE_BITS - 1)) - 1);
    localparam logic signed [PROD_W-1:0] VMIN_P = -VMAX_P - PROD_W'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SWEEP_START,
        S_RD_C,
        S_RD_U,
        S_RD_D,
        S_RD_L,
        S_RD_R,
        S_MEAN,
        S_MUL,
        S_UPD,
        S_SWEEP_END
    } state_t;

    // Configuration registers.
    logic [SIDE_CFG_W-1:0] grid_side_reg;
    logic [TOL_W-1:0]      tolerance_reg;
    logic [OMEGA_W-1:0]    relax_reg;
    logic [SWEEP_W-1:0]    sweep_limit_reg;

    // Sequencer and datapath registers.
    state_t                      state_reg;
    logic [SIDE_W-1:0]           row_reg;
    logic [SIDE_W-1:0]           col_reg;
    logic [ADDR_BITS-1:0]        at_reg;
    logic signed [VALUE_BITS-1:0] old_reg;
    logic signed [SUM_W-1:0]     sum_reg;
    logic signed [DIFF_W-1:0]    diff_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic [VALUE_BITS-1:0]       largest_reg;
    logic [SWEEP_W-1:0]          sweep_cnt_reg;

    // Response register.
    logic                        out_valid_reg;
    logic                        out_rd_reg;
    logic [SWEEP_W-1:0]          out_sweeps_reg;
    logic                        out_conv_reg;

    // Grid memory: {held, potential} per cell.
    logic [VALUE_BITS:0]         mem [CELLS];
    logic [VALUE_BITS:0]         rd_data_reg;

    logic                        rd_en;
    logic [ADDR_BITS-1:0]        rd_addr;
    logic                        wr_en;
    logic [ADDR_BITS-1:0]        wr_addr;
    logic [VALUE_BITS:0]         wr_data;

    logic                        accept;
    logic                        out_free;
    logic                        in_inside;
    logic [ADDR_BITS-1:0]        in_at;
    logic [SIDE_W-1:0]           side_w;
    logic                        last_col;
    logic                        last_row;
    logic signed [VALUE_BITS-1:0] rd_val;
    logic                        rd_held;

    logic signed [SUM_W-1:0]     sum_full;
    logic signed [SUM_W-1:0]     mean_full;
    logic signed [PROD_W-1:0]    step;
    logic signed [PROD_W-1:0]    nv_full;
    logic signed [VALUE_BITS-1:0] nv;
    logic signed [DIFF_W-1:0]    delta;
    logic [VALUE_BITS-1:0]       change;
    logic [SWEEP_W-1:0]          cnt_inc;
    logic                        met_tol;

    // The grid side in use never exceeds the memory's side.
    always_comb
    begin
        if (CMP_W'(grid_side_reg) > CMP_W'(MAX_SIDE))
        begin
            side_w = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            side_w = SIDE_W'(grid_side_reg);
        end
    end

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    assign in_inside = (32'(req.row) < MAX_SIDE) && (32'(req.column) < MAX_SIDE);
    assign in_at     = ADDR_BITS'(ADDR_BITS'(req.row) * ADDR_BITS'(MAX_SIDE))
                       + ADDR_BITS'(req.column);

    assign rd_val  = rd_data_reg[VALUE_BITS-1:0];
    assign rd_held = rd_data_reg[VALUE_BITS];

    assign last_col = (col_reg == side_w - SIDE_W'(2));
    assign last_row = (row_reg == side_w - SIDE_W'(2));

    // Cell arithmetic: rounded quarter of the neighbor sum, relaxed step,
    // saturation to the value range, and the size of the change.
    assign sum_full  = sum_reg + SUM_W'(rd_val);
    assign mean_full = (sum_full + $signed(SUM_W'(2))) >>> 2;
    assign step      = (prod_reg + $signed(PROD_W'(32768))) >>> 16;
    assign nv_full   = PROD_W'(old_reg) + step;

    always_comb
    begin
        if (nv_full > VMAX_P)
        begin
            nv = VALUE_BITS'(VMAX_P);
        end
        else if (nv_full < VMIN_P)
        begin
            nv = VALUE_BITS'(VMIN_P);
        end
        else
        begin
            nv = VALUE_BITS'(nv_full);
        end
    end

    assign delta  = DIFF_W'(nv) - DIFF_W'(old_reg);
    assign change = (delta < 0) ? VALUE_BITS'(-delta) : VALUE_BITS'(delta);

    assign cnt_inc = sweep_cnt_reg + SWEEP_W'(1);
    assign met_tol = CHG_CMP_W'(largest_reg) < CHG_CMP_W'(tolerance_reg);

    // Memory port control.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = at_reg;
        wr_en   = 1'b0;
        wr_addr = at_reg;
        wr_data = {1'b0, nv};
        case (state_reg)
            S_IDLE:
            begin
                rd_addr = in_at;
                wr_addr = in_at;
                wr_data = {req.held, req.cell_in};
                rd_en   = accept && (req.mode == MODE_READ) && in_inside;
                wr_en   = accept && (req.mode == MODE_WRITE) && in_inside;
            end
            S_RD_C:
            begin
                rd_en = 1'b1;
            end
            S_RD_U:
            begin
                rd_en   = !rd_held;
                rd_addr = at_reg - ADDR_BITS'(MAX_SIDE);
            end
            S_RD_D:
            begin
                rd_en   = 1'b1;
                rd_addr = at_reg + ADDR_BITS'(MAX_SIDE);
            end
            S_RD_L:
            begin
                rd_en   = 1'b1;
                rd_addr = at_reg - ADDR_BITS'(1);
            end
            S_RD_R:
            begin
                rd_en   = 1'b1;
                rd_addr = at_reg + ADDR_BITS'(1);
            end
            S_UPD:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Sequencer, configuration and response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg   <= GRID_SIDE_RST;
            tolerance_reg   <= TOLERANCE_RST;
            relax_reg       <= RELAX_RST;
            sweep_limit_reg <= SWEEP_LIMIT_RST;
            state_reg       <= S_IDLE;
            row_reg         <= '0;
            col_reg         <= '0;
            at_reg          <= '0;
            old_reg         <= '0;
            sum_reg         <= '0;
            diff_reg        <= '0;
            prod_reg        <= '0;
            largest_reg     <= '0;
            sweep_cnt_reg   <= '0;
            out_valid_reg   <= 1'b0;
            out_rd_reg      <= 1'b0;
            out_sweeps_reg  <= '0;
            out_conv_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GRID_SIDE:   grid_side_reg   <= cfg_data[SIDE_CFG_W-1:0];
                    REG_TOLERANCE:   tolerance_reg   <= cfg_data[TOL_W-1:0];
                    REG_RELAX:       relax_reg       <= cfg_data[OMEGA_W-1:0];
                    REG_SWEEP_LIMIT: sweep_limit_reg <= cfg_data[SWEEP_W-1:0];
                    default:         relax_reg       <= relax_reg;
                endcase
            end

            // A taken word empties the register unless a new write, read or
            // unused-mode word refills it at the same edge.
            if (rsp.valid && rsp.ready && !(accept && (req.mode != MODE_SOLVE)))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        out_rd_reg     <= (req.mode == MODE_READ) && in_inside;
                        out_sweeps_reg <= '0;
                        out_conv_reg   <= 1'b0;
                        if (req.mode == MODE_SOLVE)
                        begin
                            sweep_cnt_reg <= '0;
                            state_reg     <= S_SWEEP_START;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                S_SWEEP_START:
                begin
                    largest_reg <= '0;
                    row_reg     <= SIDE_W'(1);
                    col_reg     <= SIDE_W'(1);
                    at_reg      <= ADDR_BITS'(MAX_SIDE + 1);
                    if (side_w < SIDE_W'(3))
                    begin
                        state_reg <= S_SWEEP_END;
                    end
                    else
                    begin
                        state_reg <= S_RD_C;
                    end
                end
                S_RD_C:
                begin
                    state_reg <= S_RD_U;
                end
                S_RD_U:
                begin
                    old_reg <= rd_val;
                    if (!rd_held)
                    begin
                        state_reg <= S_RD_D;
                    end
                end
                S_RD_D:
                begin
                    sum_reg   <= SUM_W'(rd_val);
                    state_reg <= S_RD_L;
                end
                S_RD_L:
                begin
                    sum_reg   <= sum_full;
                    state_reg <= S_RD_R;
                end
                S_RD_R:
                begin
                    sum_reg   <= sum_full;
                    state_reg <= S_MEAN;
                end
                S_MEAN:
                begin
                    diff_reg  <= DIFF_W'(mean_full) - DIFF_W'(old_reg);
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg  <= PROD_W'($signed({1'b0, relax_reg})) * PROD_W'(diff_reg);
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (change > largest_reg)
                    begin
                        largest_reg <= change;
                    end
                end
                S_SWEEP_END:
                begin
                    sweep_cnt_reg <= cnt_inc;
                    if (met_tol || (cnt_inc >= sweep_limit_reg))
                    begin
                        out_valid_reg  <= 1'b1;
                        out_rd_reg     <= 1'b0;
                        out_sweeps_reg <= cnt_inc;
                        out_conv_reg   <= met_tol;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_SWEEP_START;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Step to the next interior cell after an update, or right away
            // when the current cell is held.
            if ((state_reg == S_UPD) || ((state_reg == S_RD_U) && rd_held))
            begin
                if (last_col && last_row)
                begin
                    state_reg <= S_SWEEP_END;
                end
                else if (last_col)
                begin
                    row_reg   <= row_reg + SIDE_W'(1);
                    col_reg   <= SIDE_W'(1);
                    at_reg    <= at_reg + ADDR_BITS'(MAX_SIDE)
                                 - ADDR_BITS'(side_w) + ADDR_BITS'(3);
                    state_reg <= S_RD_C;
                end
                else
                begin
                    col_reg   <= col_reg + SIDE_W'(1);
                    at_reg    <= at_reg + ADDR_BITS'(1);
                    state_reg <= S_RD_C;
                end
            end
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.cell_out  = out_rd_reg ? rd_val : '0;
    assign rsp.sweeps    = out_sweeps_reg;
    assign rsp.converged = out_conv_reg;

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    import lrs_pkg::*;

    // Geometry and value range of the grid, taken from the package defaults.
    localparam int SIDE_MAX   = MAX_SIDE_DEF;
    localparam int VB         = VALUE_BITS_DEF;
    localparam int CELL_COUNT = SIDE_MAX * SIDE_MAX;
    localparam int POT_MAX    = (1 << (VB - 1)) - 1;
    localparam int POT_MIN    = -(1 << (VB - 1));

    // The mode field has one code that the block does not use.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // The long receiver hold, in cycles. It must outlast the one-word response
    // register so that the block backs up and drops req.ready.
    localparam int LONG_HOLD = 300;

    // The longest correct stretch with no handshake on either channel is a
    // solve on an 8 x 8 grid with 30 sweeps over its 36 interior cells. The limit
    // is set well above the length of such a solve.
    localparam int WATCHDOG_LIMIT = 50000;

    // Only the first mismatches are printed; all of them are counted.
    localparam int PRINT_CAP = 50;

    // One request word as it travels on the req channel.
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [INDEX_W-1:0] row;
        logic [INDEX_W-1:0] column;
        logic [VB-1:0]      cell_in;
        logic               held;
    } grid_word_t;

    // One response word as it travels on the rsp channel.
    typedef struct packed {
        logic [VB-1:0]      cell_out;
        logic [SWEEP_W-1:0] sweeps;
        logic               converged;
    } grid_reply_t;

    // One line of the directed script: either a register write or a word.
    // Words marked typed carry their answer in the script itself; all others
    // are checked against the grid predictor.
    typedef struct packed {
        logic                  is_reg;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        grid_word_t            word;
        logic                  typed;
        grid_reply_t           answer;
    } script_row_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lrs_req_if #(.VALUE_BITS(VB)) req_ch ();
    lrs_rsp_if #(.VALUE_BITS(VB)) rsp_ch ();

    laplace_relaxation_solver #(
        .MAX_SIDE   (SIDE_MAX),
        .VALUE_BITS (VB)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the grid and of the registers, kept by the predictor.
    logic [VB-1:0] cell_pot   [CELL_COUNT];
    bit            cell_fixed [CELL_COUNT];
    bit            cell_known [CELL_COUNT];
    int            cfg_side;
    int            cfg_tol;
    int            cfg_omega;
    int            cfg_limit;

    // Answers owed by the block, oldest first.
    grid_reply_t   replies_due [$];

    int error_count  = 0;
    int quiet_cycles = 0;

    // Idle rates in percent, changed by the stimulus as the run moves from one
    // idling pattern to the next.
    int sender_idle_pct   = 9;
    int receiver_idle_pct = 80;

    // Set by the stimulus to ask the receiver for one long hold.
    bit long_hold_pending = 1'b0;

    initial begin
        clk = 1'b0;
        forever begin
            #5 clk = ~clk;
        end
    end

    // Every mismatch goes through here, so that the count and the printout
    // cannot drift apart.
    task automatic flag_error(string msg);
        if (error_count < PRINT_CAP) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        error_count++;
    endtask

    function automatic longint pot_of(int at);
        return longint'($signed(cell_pot[at]));
    endfunction

    // One in-place Gauss-Seidel sweep over the interior of the grid in use.
    // Cells are visited in row-major order, so the upper and left neighbors
    // already hold their values from this sweep. Returns the largest change.
    function automatic longint relax_grid(int side);
        longint worst;
        longint old_v;
        longint sum;
        longint mean;
        longint nudge;
        longint fresh;
        longint change;
        int     at;
        int     i;
        int     j;
        worst = 0;
        for (i = 1; i + 1 < side; i++) begin
            for (j = 1; j + 1 < side; j++) begin
                at = i * SIDE_MAX + j;
                if (!cell_fixed[at]) begin
                    old_v = pot_of(at);
                    sum   = pot_of(at + SIDE_MAX) + pot_of(at - SIDE_MAX)
                          + pot_of(at + 1) + pot_of(at - 1);
                    // Mean rounds half up; the relaxed step rounds half up too.
                    // Arithmetic shifts of signed values give the floor.
                    mean  = (sum + 2) >>> 2;
                    nudge = (longint'(cfg_omega) * (mean - old_v) + 64'sd32768) >>> 16;
                    fresh = old_v + nudge;
                    if (fresh > POT_MAX) begin
                        fresh = longint'(POT_MAX);
                    end
                    if (fresh < POT_MIN) begin
                        fresh = longint'(POT_MIN);
                    end
                    cell_pot[at] = fresh[VB-1:0];
                    change = (fresh >= old_v) ? fresh - old_v : old_v - fresh;
                    if (change > worst) begin
                        worst = change;
                    end
                end
            end
        end
        return worst;
    endfunction

    // Applies one accepted word to the shadow grid and returns the answer the
    // block owes for it.
    function automatic grid_reply_t grid_reply(grid_word_t w);
        grid_reply_t a;
        int          at;
        int          side;
        int          limit;
        int          count;
        longint      worst;
        bit          done;
        a  = '0;
        at = int'(w.row) * SIDE_MAX + int'(w.column);
        case (w.mode)
            MODE_WRITE: begin
                cell_pot[at]   = w.cell_in;
                cell_fixed[at] = w.held;
                cell_known[at] = 1'b1;
            end
            MODE_SOLVE: begin
                // A side above the store is clipped; a zero sweep limit still
                // allows one sweep.
                side  = (cfg_side > SIDE_MAX) ? SIDE_MAX : cfg_side;
                limit = (cfg_limit == 0) ? 1 : cfg_limit;
                count = 0;
                done  = 1'b0;
                while (!done) begin
                    worst = relax_grid(side);
                    count++;
                    if (worst < longint'(cfg_tol)) begin
                        done        = 1'b1;
                        a.converged = 1'b1;
                    end else if (count >= limit) begin
                        done = 1'b1;
                    end
                end
                a.sweeps = count[SWEEP_W-1:0];
            end
            MODE_READ: begin
                a.cell_out = cell_pot[at];
            end
            default: begin
                // The unused code leaves everything alone and answers zero.
            end
        endcase
        return a;
    endfunction

    function automatic grid_word_t make_word(logic [MODE_W-1:0] m, int r, int c, int v,
                                             bit h);
        grid_word_t w;
        w.mode    = m;
        w.row     = r[INDEX_W-1:0];
        w.column  = c[INDEX_W-1:0];
        w.cell_in = v[VB-1:0];
        w.held    = h;
        return w;
    endfunction

    function automatic script_row_t step_row(logic [MODE_W-1:0] m, int r, int c, int v,
                                             bit h, bit typed, int want);
        script_row_t s;
        s                 = '0;
        s.word            = make_word(m, r, c, v, h);
        s.typed           = typed;
        s.answer.cell_out = want[VB-1:0];
        return s;
    endfunction

    function automatic script_row_t reg_row(logic [CFG_IDX_W-1:0] index, int value);
        script_row_t s;
        s           = '0;
        s.is_reg    = 1'b1;
        s.reg_index = index;
        s.reg_value = value[CFG_DATA_W-1:0];
        return s;
    endfunction

    // Random potentials, with the two extremes coming up often.
    function automatic int rand_potential();
        case ($urandom_range(0, 9))
            0:       return POT_MAX;
            1:       return POT_MIN;
            default: return int'($urandom_range(0, (1 << VB) - 1)) + POT_MIN;
        endcase
    endfunction

    // Offers one word and waits for the handshake. The word is applied to the
    // predictor at the edge where it is accepted. The caller is always at a
    // rising edge, so valid gets exactly one assignment per time step here.
    task automatic send_word(grid_word_t w, bit typed, grid_reply_t typed_answer);
        grid_reply_t reply;
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            req_ch.valid <= 1'b0;
            do begin
                @(posedge clk);
            end while ($urandom_range(0, 99) < sender_idle_pct);
        end
        req_ch.valid   <= 1'b1;
        req_ch.mode    <= w.mode;
        req_ch.row     <= w.row;
        req_ch.column  <= w.column;
        req_ch.cell_in <= w.cell_in;
        req_ch.held    <= w.held;
        do begin
            @(posedge clk);
        end while (req_ch.ready !== 1'b1);
        reply = grid_reply(w);
        replies_due.push_back(typed ? typed_answer : reply);
    endtask

    task automatic pause_sender();
        req_ch.valid <= 1'b0;
    endtask

    // Waits until the block owes nothing, plus a few cycles so that the
    // response register is surely empty before registers change.
    task automatic wait_drained();
        while (replies_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Writes one register and mirrors it, masked to the register's width.
    task automatic set_register(logic [CFG_IDX_W-1:0] index, int value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (index)
            REG_GRID_SIDE:   cfg_side  = value & 'h7F;
            REG_TOLERANCE:   cfg_tol   = value & 'hFFFF;
            REG_RELAX:       cfg_omega = value & 'h1FFFF;
            REG_SWEEP_LIMIT: cfg_limit = value & 'hFFFF;
            default: begin
            end
        endcase
    endtask

    // One phase of the random part: the block is drained and reconfigured,
    // the grid in use is loaded in full with a held border, and then a mix of
    // writes, reads, solves and unused-mode words follows. When squeeze is
    // set, the receiver holds off for a long stretch while the load runs.
    task automatic run_phase(int side, int tol, int omega, int limit, int mixed,
                             bit squeeze);
        int  span;
        int  r;
        int  c;
        int  n;
        int  pick;
        bit  rim;
        pause_sender();
        wait_drained();
        set_register(REG_GRID_SIDE, side);
        set_register(REG_TOLERANCE, tol);
        set_register(REG_RELAX, omega);
        set_register(REG_SWEEP_LIMIT, limit);
        if (squeeze) begin
            long_hold_pending = 1'b1;
        end
        span = (side > SIDE_MAX) ? SIDE_MAX : side;
        for (r = 0; r < span; r++) begin
            for (c = 0; c < span; c++) begin
                rim = (r == 0) || (c == 0) || (r == span - 1) || (c == span - 1);
                send_word(make_word(MODE_WRITE, r, c, rand_potential(),
                                    rim || ($urandom_range(0, 4) == 0)), 1'b0, '0);
            end
        end
        for (n = 0; n < mixed; n++) begin
            pick = $urandom_range(0, 99);
            // Most cell words land inside the grid in use; the rest anywhere.
            if (span > 0 && $urandom_range(0, 3) != 0) begin
                r = $urandom_range(0, span - 1);
                c = $urandom_range(0, span - 1);
            end else begin
                r = $urandom_range(0, SIDE_MAX - 1);
                c = $urandom_range(0, SIDE_MAX - 1);
            end
            if (pick < 55) begin
                send_word(make_word(MODE_WRITE, r, c, rand_potential(),
                                    $urandom_range(0, 3) == 0), 1'b0, '0);
            end else if (pick < 85) begin
                // A read of a cell that was never written goes to the corner
                // that the directed script always loads.
                if (!cell_known[r * SIDE_MAX + c]) begin
                    r = 0;
                    c = 0;
                end
                send_word(make_word(MODE_READ, r, c, rand_potential(),
                                    1'($urandom_range(0, 1))), 1'b0, '0);
            end else if (pick < 94) begin
                send_word(make_word(MODE_SOLVE, r, c, rand_potential(),
                                    1'($urandom_range(0, 1))), 1'b0, '0);
            end else begin
                send_word(make_word(MODE_UNUSED, r, c, rand_potential(),
                                    1'($urandom_range(0, 1))), 1'b0, '0);
            end
        end
    endtask

    // Receiver: takes result words at the current idle rate, and once, when
    // asked, holds ready low for a long stretch counted here.
    initial begin : receiver
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold_pending) begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_pending = 1'b0;
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Result check: every accepted result word is compared field by field with
    // the oldest answer owed.
    always @(posedge clk) begin : result_check
        grid_reply_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (replies_due.size() == 0) begin
                flag_error("result word arrived with none due");
            end else begin
                want = replies_due.pop_front();
                if (rsp_ch.cell_out !== want.cell_out) begin
                    flag_error($sformatf("cell_out %0d, want %0d",
                                         $signed(rsp_ch.cell_out), $signed(want.cell_out)));
                end
                if (rsp_ch.sweeps !== want.sweeps) begin
                    flag_error($sformatf("sweeps %0d, want %0d", rsp_ch.sweeps, want.sweeps));
                end
                if (rsp_ch.converged !== want.converged) begin
                    flag_error($sformatf("converged %0b, want %0b",
                                         rsp_ch.converged, want.converged));
                end
            end
        end
    end

    // Watchdog: a run that stops moving on both channels for too long is a
    // hang, whatever the cause.
    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        script_row_t script [$];
        script_row_t line;
        int          phase;
        int          tol;
        int          omega;

        // All block inputs start at known values.
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.mode    <= MODE_WRITE;
        req_ch.row     <= '0;
        req_ch.column  <= '0;
        req_ch.cell_in <= '0;
        req_ch.held    <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= REG_GRID_SIDE;
        cfg_data       <= '0;

        // The predictor starts from the register defaults. The grid itself is
        // undefined after reset, so nothing reads or sweeps a cell before it
        // has been written.
        cfg_side  = int'(GRID_SIDE_RST);
        cfg_tol   = int'(TOLERANCE_RST);
        cfg_omega = int'(RELAX_RST);
        cfg_limit = int'(SWEEP_LIMIT_RST);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed script. First, with the reset registers, the corners of the
        // store are written, two at the extremes, and read back unchanged; the
        // unused mode answers zero and leaves the cell it names alone.
        script.push_back(step_row(MODE_WRITE, 0, 0, POT_MAX, 1'b1, 1'b0, 0));
        script.push_back(step_row(MODE_WRITE, 63, 63, POT_MIN, 1'b0, 1'b0, 0));
        script.push_back(step_row(MODE_WRITE, 0, 63, 0, 1'b1, 1'b0, 0));
        script.push_back(step_row(MODE_WRITE, 63, 0, -1, 1'b0, 1'b0, 0));
        script.push_back(step_row(MODE_READ, 0, 0, 0, 1'b0, 1'b1, POT_MAX));
        script.push_back(step_row(MODE_READ, 63, 63, -1, 1'b1, 1'b1, POT_MIN));
        script.push_back(step_row(MODE_READ, 63, 0, 0, 1'b0, 1'b1, -1));
        script.push_back(step_row(MODE_UNUSED, 63, 63, -1, 1'b1, 1'b1, 0));
        script.push_back(step_row(MODE_READ, 63, 63, 0, 1'b0, 1'b1, POT_MIN));
        script.push_back(step_row(MODE_READ, 0, 63, 0, 1'b0, 1'b1, 0));

        // Then the smallest grid with a single free cell, pulled hard towards
        // the top by an omega near two so that the update saturates, and a
        // short sweep limit because that setting oscillates.
        script.push_back(reg_row(REG_GRID_SIDE, 3));
        script.push_back(reg_row(REG_RELAX, 131071));
        script.push_back(reg_row(REG_SWEEP_LIMIT, 4));
        script.push_back(step_row(MODE_WRITE, 0, 0, POT_MAX, 1'b1, 1'b0, 0));
        script.push_back(step_row(MODE_WRITE, 0, 1, POT_MAX, 1'b1, 1'b0, 0));
        script.push_back(step_row(MODE_WRITE, 0, 2, POT_MAX, 1'b1, 1'b0, 0));
        script.push_back(step_row(MODE_WRITE, 1, 0, POT_MAX, 1'b1, 1'b0, 0));
        script.push_back(step_row(MODE_WRITE, 1, 1, POT_MIN, 1'b0, 1'b0, 0));
        script.push_back(step_row(MODE_WRITE, 1, 2, POT_MAX, 1'b1, 1'b0, 0));
        script.push_back(step_row(MODE_WRITE, 2, 0, POT_MIN, 1'b1, 1'b0, 0));
        script.push_back(step_row(MODE_WRITE, 2, 1, POT_MIN, 1'b1, 1'b0, 0));
        script.push_back(step_row(MODE_WRITE, 2, 2, POT_MIN, 1'b1, 1'b0, 0));
        script.push_back(step_row(MODE_SOLVE, 0, 0, 0, 1'b0, 1'b0, 0));
        script.push_back(step_row(MODE_READ, 1, 1, 0, 1'b0, 1'b0, 0));

        // Plain Gauss-Seidel on the same cell settles in two sweeps.
        script.push_back(reg_row(REG_RELAX, 65536));
        script.push_back(step_row(MODE_SOLVE, 63, 63, -1, 1'b1, 1'b0, 0));
        script.push_back(step_row(MODE_READ, 1, 1, 0, 1'b0, 1'b0, 0));

        foreach (script[k]) begin
            line = script[k];
            if (line.is_reg) begin
                pause_sender();
                wait_drained();
                set_register(line.reg_index, int'(line.reg_value));
            end else begin
                send_word(line.word, line.typed, line.answer);
            end
        end

        // Random phases on small grids. The first five pin the register
        // extremes: the largest sweep limit on a grid that settles, sides too
        // small to have an interior, a zero tolerance, a zero sweep limit, and
        // the largest tolerance and omega. The idle pattern changes every five
        // phases, and the first phase without idling also gets the long
        // receiver hold.
        for (phase = 0; phase < 15; phase++) begin
            if (phase == 5) begin
                sender_idle_pct   = 80;
                receiver_idle_pct = 9;
            end
            if (phase == 10) begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            case (phase)
                0: run_phase(3, 1, 65536, 65535, 30, 1'b0);
                1: run_phase(2, 0, 0, 0, 20, 1'b0);
                2: run_phase(8, 65535, 131071, 1, 30, 1'b0);
                3: run_phase(0, 300, 98304, 3, 20, 1'b0);
                4: run_phase(1, 0, 131071, 2, 20, 1'b0);
                default: begin
                    tol = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                      : $urandom_range(16, 3000);
                    case ($urandom_range(0, 5))
                        0:       omega = 0;
                        1:       omega = 65536;
                        2:       omega = 131071;
                        default: omega = $urandom_range(30000, 131071);
                    endcase
                    run_phase($urandom_range(3, 8), tol, omega, $urandom_range(1, 30), 30,
                              phase == 10);
                end
            endcase
        end

        // Let everything owed come back, then give any stray word time to
        // show up before the verdict.
        pause_sender();
        wait_drained();
        repeat (16) @(posedge clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
